/* sv/cursor_sprite_save_under_blitter_macros.svh */
// Assertion helpers for the cursor blitter
`ifndef CURSOR_SPRITE_SAVE_UNDER_BLITTER_MACROS_SVH
`define CURSOR_SPRITE_SAVE_UNDER_BLITTER_MACROS_SVH

// a implies c in the same cycle
`define CSB_ASSERT_SAME(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("csb assertion failed");

// a implies c in the next cycle
`define CSB_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("csb assertion failed");

`endif

/* sv/csb_pkg.sv */
package csb_pkg;

  localparam int CURSOR_SIZE = 16;
  localparam int OFFSET_BITS = 24;
  localparam int PIXEL_BITS  = 16;

  typedef enum logic [1:0] {
    KIND_SHAPE  = 2'd0,
    KIND_COLOUR = 2'd1,
    KIND_CMD    = 2'd2,
    KIND_RESP   = 2'd3
  } kind_t;

  localparam logic [2:0] OP_MOVE   = 3'd0;
  localparam logic [2:0] OP_HIDE_A = 3'd2;
  localparam logic [2:0] OP_SHOW   = 3'd3;
  localparam logic [2:0] OP_HIDE_B = 3'd4;

  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_DONE  = 2'd2;

  localparam logic [2:0] CFG_MIN_X   = 3'd0;
  localparam logic [2:0] CFG_MAX_X   = 3'd1;
  localparam logic [2:0] CFG_MIN_Y   = 3'd2;
  localparam logic [2:0] CFG_MAX_Y   = 3'd3;
  localparam logic [2:0] CFG_STRIDE  = 3'd4;
  localparam logic [2:0] CFG_HOT_X   = 3'd5;
  localparam logic [2:0] CFG_HOT_Y   = 3'd6;
  localparam logic [2:0] CFG_RESTORE = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE, PH_RESTORE, PH_READ, PH_WRITE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_CLIP, ST_ORIGIN, ST_ADDR, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RES_DONE, RES_READ, RES_RESTORE, RES_PAINT
  } res_t;

  typedef struct packed {
    logic capture;
    logic load_shape;
    logic load_colour;
    logic restore_init;
    logic adv;
    logic clr_valid;
    logic save_pixel;
    logic clip;
    logic origin;
    logic addr;
    logic emit;
    res_t res;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] op;
    logic       saved_valid;
    logic       restore_en;
    logic       draw_pending;
    logic       adv_last;
    logic       clip_empty;
    logic       pix_hit;
  } sts_t;

  // default arrow: mask rows then data rows
  localparam logic [15:0] ARROW_MASK [CURSOR_SIZE] = '{
    16'hffff, 16'h7ffe, 16'h3ffc, 16'h1ff8, 16'h0ff0, 16'h07e0, 16'h03c0, 16'h0180,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };
  localparam logic [15:0] ARROW_DATA [CURSOR_SIZE] = '{
    16'h0000, 16'h3ffc, 16'h1ff8, 16'h0ff0, 16'h07e0, 16'h03c0, 16'h0180, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

endpackage

/* sv/csb_datapath.sv */
module csb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  csb_pkg::cmd_t       cmd,
  output csb_pkg::sts_t       sts,
  input  logic [1:0]          in_kind,
  input  logic [2:0]          in_op,
  input  logic [15:0]         in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic [3:0]          in_row_index,
  input  logic [15:0]         in_mask_row,
  input  logic [15:0]         in_data_row,
  input  logic [15:0]         in_fg_colour,
  input  logic [15:0]         in_bg_colour,
  input  logic [15:0]         in_read_pixel,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  output logic [1:0]          out_access,
  output logic [23:0]         out_pixel_offset,
  output logic [15:0]         out_write_pixel
);

  logic [1:0]         kind_r;
  logic [2:0]         op_r;
  logic [15:0]        px_r;
  logic signed [15:0] py_r;
  logic [3:0]         ri_r;
  logic [15:0]        mask_in_r, data_in_r, fg_in_r, bg_in_r, rp_r;

  logic [11:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [13:0] stride_r;
  logic [3:0]  hot_x_r, hot_y_r;
  logic        restore_en_r;

  logic [15:0] mask_tbl_r [csb_pkg::CURSOR_SIZE];
  logic [15:0] data_tbl_r [csb_pkg::CURSOR_SIZE];
  logic [15:0] sbuf [256];
  logic [15:0] sbuf_rdata_r;

  logic        saved_valid_r, draw_pending_r;
  logic [23:0] origin_r, cur_off_r;
  logic [3:0]  wl1_r, hl1_r, ls_r, fsr_r, col_r, row_r;
  logic [15:0] fore_r, back_r;
  logic        dbit_r;

  logic [15:0] clip_x_r, clip_y_r;
  logic [3:0]  clip_wl1_r, clip_hl1_r, clip_ls_r, clip_fsr_r;
  logic        clip_empty_r;

  logic        out_valid_r;
  logic [1:0]  out_access_r;
  logic [23:0] out_off_r;
  logic [15:0] out_pix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r      <= 12'd0;
      max_x_r      <= 12'd639;
      min_y_r      <= 12'd0;
      max_y_r      <= 12'd479;
      stride_r     <= 14'd640;
      hot_x_r      <= 4'd0;
      hot_y_r      <= 4'd0;
      restore_en_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csb_pkg::CFG_MIN_X:   min_x_r      <= cfg_data[11:0];
        csb_pkg::CFG_MAX_X:   max_x_r      <= cfg_data[11:0];
        csb_pkg::CFG_MIN_Y:   min_y_r      <= cfg_data[11:0];
        csb_pkg::CFG_MAX_Y:   max_y_r      <= cfg_data[11:0];
        csb_pkg::CFG_STRIDE:  stride_r     <= cfg_data[13:0];
        csb_pkg::CFG_HOT_X:   hot_x_r      <= cfg_data[3:0];
        csb_pkg::CFG_HOT_Y:   hot_y_r      <= cfg_data[3:0];
        csb_pkg::CFG_RESTORE: restore_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= in_kind;
      op_r      <= in_op;
      px_r      <= in_pos_x;
      py_r      <= in_pos_y;
      ri_r      <= in_row_index;
      mask_in_r <= in_mask_row;
      data_in_r <= in_data_row;
      fg_in_r   <= in_fg_colour;
      bg_in_r   <= in_bg_colour;
      rp_r      <= in_read_pixel;
    end
  end

  // clipping
  logic signed [19:0] cx, cy, cw, ch, cxs, cys, cw_m1, ch_m1;
  logic signed [19:0] minx_s, maxx_s, miny_s, maxy_s;
  always_comb begin
    minx_s = $signed({8'd0, min_x_r});
    maxx_s = $signed({8'd0, max_x_r});
    miny_s = $signed({8'd0, min_y_r});
    maxy_s = $signed({8'd0, max_y_r});
    cy  = $signed({{4{py_r[15]}}, py_r}) - $signed({16'd0, hot_y_r});
    ch  = 20'sd16;
    cys = 20'sd0;
    if (cy < miny_s) begin
      cys = miny_s - cy;
      ch  = 20'sd16 - cys;
      cy  = miny_s;
    end
    if (cy + ch - 20'sd1 > maxy_s) ch = maxy_s - cy + 20'sd1;
    cx  = $signed({4'd0, px_r}) - $signed({16'd0, hot_x_r});
    cw  = 20'sd16;
    cxs = 20'sd0;
    if (cx < minx_s) begin
      cxs = minx_s - cx;
      cw  = 20'sd16 - cxs;
      cx  = minx_s;
    end
    if (cx + cw - 20'sd1 > maxx_s) cw = maxx_s - cx + 20'sd1;
    cw_m1 = cw - 20'sd1;
    ch_m1 = ch - 20'sd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clip) begin
      clip_x_r     <= cx[15:0];
      clip_y_r     <= cy[15:0];
      clip_wl1_r   <= cw_m1[3:0];
      clip_hl1_r   <= ch_m1[3:0];
      clip_ls_r    <= cxs[3:0];
      clip_fsr_r   <= cys[3:0];
      clip_empty_r <= (cw <= 20'sd0) || (ch <= 20'sd0);
    end
  end

  logic [29:0] org_prod;
  logic [30:0] org_sum;
  assign org_prod = clip_y_r * stride_r;
  assign org_sum  = {1'b0, org_prod} + {15'd0, clip_x_r};

  logic [17:0] row_prod;
  logic [24:0] off_sum;
  assign row_prod = row_r * stride_r;
  assign off_sum  = {1'b0, origin_r} + {7'd0, row_prod} + {21'd0, col_r};

  logic [4:0] col_inc, row_inc;
  logic       col_wrap;
  assign col_inc  = {1'b0, col_r} + 5'd1;
  assign row_inc  = {1'b0, row_r} + 5'd1;
  assign col_wrap = col_inc > {1'b0, wl1_r};

  logic [3:0] sr, bsel;
  logic [4:0] pos;
  logic       mbit, dbit;
  assign sr   = fsr_r + row_r;
  assign pos  = {1'b0, ls_r} + {1'b0, col_r};
  assign bsel = 4'd15 - pos[3:0];
  assign mbit = !pos[4] && mask_tbl_r[sr][bsel];
  assign dbit = !pos[4] && data_tbl_r[sr][bsel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < csb_pkg::CURSOR_SIZE; i++) begin
        mask_tbl_r[i] <= csb_pkg::ARROW_MASK[i];
        data_tbl_r[i] <= csb_pkg::ARROW_DATA[i];
      end
      fore_r <= 16'hffff;
      back_r <= 16'h0000;
    end else begin
      if (cmd.load_shape) begin
        mask_tbl_r[ri_r] <= mask_in_r;
        data_tbl_r[ri_r] <= data_in_r;
      end
      if (cmd.load_colour) begin
        fore_r <= fg_in_r;
        back_r <= bg_in_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_pixel) sbuf[{row_r, col_r}] <= rp_r;
    if (cmd.addr) sbuf_rdata_r <= sbuf[{row_r, col_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_valid_r  <= 1'b0;
      draw_pending_r <= 1'b0;
      origin_r       <= 24'd0;
      cur_off_r      <= 24'd0;
      wl1_r          <= 4'd0;
      hl1_r          <= 4'd0;
      ls_r           <= 4'd0;
      fsr_r          <= 4'd0;
      col_r          <= 4'd0;
      row_r          <= 4'd0;
    end else begin
      if (cmd.restore_init) begin
        col_r          <= 4'd0;
        row_r          <= 4'd0;
        draw_pending_r <= (op_r == csb_pkg::OP_MOVE);
      end
      if (cmd.adv) begin
        if (col_wrap) begin
          col_r <= 4'd0;
          row_r <= row_inc[3:0];
        end else begin
          col_r <= col_inc[3:0];
        end
      end
      if (cmd.clr_valid) saved_valid_r <= 1'b0;
      if (cmd.origin) begin
        draw_pending_r <= 1'b0;
        if (clip_empty_r) begin
          saved_valid_r <= 1'b0;
        end else begin
          saved_valid_r <= 1'b1;
          origin_r      <= org_sum[23:0];
          wl1_r         <= clip_wl1_r;
          hl1_r         <= clip_hl1_r;
          ls_r          <= clip_ls_r;
          fsr_r         <= clip_fsr_r;
          col_r         <= 4'd0;
          row_r         <= 4'd0;
        end
      end
      if (cmd.addr) cur_off_r <= off_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_pixel) dbit_r <= dbit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.res)
        csb_pkg::RES_READ: begin
          out_access_r <= csb_pkg::ACC_READ;
          out_off_r    <= cur_off_r;
          out_pix_r    <= 16'd0;
        end
        csb_pkg::RES_RESTORE: begin
          out_access_r <= csb_pkg::ACC_WRITE;
          out_off_r    <= cur_off_r;
          out_pix_r    <= sbuf_rdata_r;
        end
        csb_pkg::RES_PAINT: begin
          out_access_r <= csb_pkg::ACC_WRITE;
          out_off_r    <= cur_off_r;
          out_pix_r    <= dbit_r ? fore_r : back_r;
        end
        default: begin
          out_access_r <= csb_pkg::ACC_DONE;
          out_off_r    <= 24'd0;
          out_pix_r    <= 16'd0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_access       = out_access_r;
  assign out_pixel_offset = out_off_r;
  assign out_write_pixel  = out_pix_r;

  always_comb begin
    sts.kind         = csb_pkg::kind_t'(kind_r);
    sts.op           = op_r;
    sts.saved_valid  = saved_valid_r;
    sts.restore_en   = restore_en_r;
    sts.draw_pending = draw_pending_r;
    sts.adv_last     = col_wrap && (row_inc > {1'b0, hl1_r});
    sts.clip_empty   = clip_empty_r;
    sts.pix_hit      = mbit || dbit;
  end

endmodule

/* sv/csb_ctrl.sv */
`include "cursor_sprite_save_under_blitter_macros.svh"

module csb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  csb_pkg::sts_t  sts,
  output csb_pkg::cmd_t  cmd
);

  csb_pkg::state_t st_r, st_nxt;
  csb_pkg::phase_t phase_r, phase_nxt;
  csb_pkg::res_t   res_r, res_nxt;

  logic wants_restore, wants_draw;
  assign wants_restore = (sts.op == csb_pkg::OP_MOVE) || (sts.op == csb_pkg::OP_HIDE_A) ||
                         (sts.op == csb_pkg::OP_HIDE_B);
  assign wants_draw    = (sts.op == csb_pkg::OP_MOVE) || (sts.op == csb_pkg::OP_SHOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= csb_pkg::ST_IDLE;
      phase_r <= csb_pkg::PH_IDLE;
      res_r   <= csb_pkg::RES_DONE;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      res_r   <= res_nxt;
    end
  end

  assign busy = (st_r != csb_pkg::ST_IDLE);

  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.res   = res_r;
    unique case (st_r)
      csb_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          st_nxt      = csb_pkg::ST_DECODE;
        end
      end
      csb_pkg::ST_DECODE: begin
        st_nxt = csb_pkg::ST_IDLE;
        unique case (sts.kind)
          csb_pkg::KIND_SHAPE:  cmd.load_shape  = 1'b1;
          csb_pkg::KIND_COLOUR: cmd.load_colour = 1'b1;
          csb_pkg::KIND_CMD: begin
            if (phase_r != csb_pkg::PH_IDLE) begin
              st_nxt = csb_pkg::ST_IDLE;
            end else if (sts.saved_valid && sts.restore_en && wants_restore) begin
              cmd.restore_init = 1'b1;
              phase_nxt        = csb_pkg::PH_RESTORE;
              res_nxt          = csb_pkg::RES_RESTORE;
              st_nxt           = csb_pkg::ST_ADDR;
            end else if (wants_draw) begin
              st_nxt = csb_pkg::ST_CLIP;
            end else begin
              res_nxt = csb_pkg::RES_DONE;
              st_nxt  = csb_pkg::ST_EMIT;
            end
          end
          default: begin
            unique case (phase_r)
              csb_pkg::PH_RESTORE: begin
                cmd.adv = 1'b1;
                if (!sts.adv_last) begin
                  res_nxt = csb_pkg::RES_RESTORE;
                  st_nxt  = csb_pkg::ST_ADDR;
                end else begin
                  cmd.clr_valid = 1'b1;
                  if (sts.draw_pending) begin
                    st_nxt = csb_pkg::ST_CLIP;
                  end else begin
                    phase_nxt = csb_pkg::PH_IDLE;
                    res_nxt   = csb_pkg::RES_DONE;
                    st_nxt    = csb_pkg::ST_EMIT;
                  end
                end
              end
              csb_pkg::PH_READ, csb_pkg::PH_WRITE: begin
                if (phase_r == csb_pkg::PH_READ) cmd.save_pixel = 1'b1;
                if ((phase_r == csb_pkg::PH_READ) && sts.pix_hit) begin
                  phase_nxt = csb_pkg::PH_WRITE;
                  res_nxt   = csb_pkg::RES_PAINT;
                  st_nxt    = csb_pkg::ST_EMIT;
                end else begin
                  cmd.adv = 1'b1;
                  if (!sts.adv_last) begin
                    phase_nxt = csb_pkg::PH_READ;
                    res_nxt   = csb_pkg::RES_READ;
                    st_nxt    = csb_pkg::ST_ADDR;
                  end else begin
                    phase_nxt = csb_pkg::PH_IDLE;
                    res_nxt   = csb_pkg::RES_DONE;
                    st_nxt    = csb_pkg::ST_EMIT;
                  end
                end
              end
              default: st_nxt = csb_pkg::ST_IDLE;
            endcase
          end
        endcase
      end
      csb_pkg::ST_CLIP: begin
        cmd.clip = 1'b1;
        st_nxt   = csb_pkg::ST_ORIGIN;
      end
      csb_pkg::ST_ORIGIN: begin
        cmd.origin = 1'b1;
        if (sts.clip_empty) begin
          phase_nxt = csb_pkg::PH_IDLE;
          res_nxt   = csb_pkg::RES_DONE;
          st_nxt    = csb_pkg::ST_EMIT;
        end else begin
          phase_nxt = csb_pkg::PH_READ;
          res_nxt   = csb_pkg::RES_READ;
          st_nxt    = csb_pkg::ST_ADDR;
        end
      end
      csb_pkg::ST_ADDR: begin
        cmd.addr = 1'b1;
        st_nxt   = csb_pkg::ST_EMIT;
      end
      csb_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        st_nxt   = csb_pkg::ST_IDLE;
      end
      default: st_nxt = csb_pkg::ST_IDLE;
    endcase
  end

  `CSB_ASSERT_NEXT(a_accept_decodes, start && !busy, st_r == csb_pkg::ST_DECODE)
  `CSB_ASSERT_NEXT(a_addr_then_emit, st_r == csb_pkg::ST_ADDR, st_r == csb_pkg::ST_EMIT)
  `CSB_ASSERT_NEXT(a_emit_then_idle, st_r == csb_pkg::ST_EMIT, st_r == csb_pkg::ST_IDLE)
  `CSB_ASSERT_SAME(a_idle_phase_done,
                   (st_r == csb_pkg::ST_EMIT) && (res_r == csb_pkg::RES_DONE),
                   phase_r == csb_pkg::PH_IDLE)

endmodule

/* sv/cursor_sprite_save_under_blitter.sv */
// 16x16 save-under cursor engine. Every accepted item (start high while busy is low) passes
// the decode state, where a shape row, colour load or ignored item ends; others end in the
// emit state, a read request or restore write via the address state and a draw start also
// via the clip and origin states. The sequencer handles one item at a time, so busy stays
// high until the item is done and any result is registered. A result appears for exactly
// one cycle with out_valid high, in the same cycle that busy falls, and the receiver cannot
// stall it; the next item may start in that cycle. Configuration is taken on any cycle.
module cursor_sprite_save_under_blitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [2:0]         in_op,
  input  logic [15:0]        in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [3:0]         in_row_index,
  input  logic [15:0]        in_mask_row,
  input  logic [15:0]        in_data_row,
  input  logic [15:0]        in_fg_colour,
  input  logic [15:0]        in_bg_colour,
  input  logic [15:0]        in_read_pixel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_access,
  output logic [23:0]        out_pixel_offset,
  output logic [15:0]        out_write_pixel
);

  csb_pkg::cmd_t cmd;
  csb_pkg::sts_t sts;

  csb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  csb_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_op            (in_op),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_row_index     (in_row_index),
    .in_mask_row      (in_mask_row),
    .in_data_row      (in_data_row),
    .in_fg_colour     (in_fg_colour),
    .in_bg_colour     (in_bg_colour),
    .in_read_pixel    (in_read_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_access       (out_access),
    .out_pixel_offset (out_pixel_offset),
    .out_write_pixel  (out_write_pixel)
  );

endmodule

/* dv/tb_cursor_sprite_save_under_blitter.sv */
`timescale 1ns / 1ps

module tb_cursor_sprite_save_under_blitter;
  import csb_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  kind_t              in_kind;
  logic [2:0]         in_op;
  logic [15:0]        in_pos_x;
  logic signed [15:0] in_pos_y;
  logic [3:0]         in_row_index;
  logic [15:0]        in_mask_row;
  logic [15:0]        in_data_row;
  logic [15:0]        in_fg_colour;
  logic [15:0]        in_bg_colour;
  logic [15:0]        in_read_pixel;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               out_valid;
  logic [1:0]         out_access;
  logic [23:0]        out_pixel_offset;
  logic [15:0]        out_write_pixel;

  cursor_sprite_save_under_blitter DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_op(in_op), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_row_index(in_row_index), .in_mask_row(in_mask_row), .in_data_row(in_data_row),
    .in_fg_colour(in_fg_colour), .in_bg_colour(in_bg_colour),
    .in_read_pixel(in_read_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_access(out_access),
    .out_pixel_offset(out_pixel_offset), .out_write_pixel(out_write_pixel)
  );

  typedef struct {
    kind_t              kind;
    logic [2:0]         op;
    logic [15:0]        x;
    logic signed [15:0] y;
    logic [3:0]         row_idx;
    logic [15:0]        mask;
    logic [15:0]        data;
    logic [15:0]        fg;
    logic [15:0]        bg;
    logic [15:0]        rd;
  } item_t;

  typedef struct {
    logic [1:0]  acc;
    logic [23:0] off;
    logic [15:0] pix;
  } access_t;

  // blitter model state
  int          win_x0, win_x1, win_y0, win_y1, stride, hot_x, hot_y;
  logic        restore_on;
  logic [15:0] shape_mask [CURSOR_SIZE];
  logic [15:0] shape_data [CURSOR_SIZE];
  logic [15:0] saved_px [CURSOR_SIZE*CURSOR_SIZE];
  logic        saved_ok;
  logic [23:0] box_origin;
  int          box_w1, box_h1;
  logic [15:0] fore_px, back_px;
  phase_t      seq_phase;
  int          col, row, lshift, row0;
  logic [23:0] cur_off;
  logic        draw_after;

  access_t     access_q[$];
  int          errors;
  int          n_items;
  int          gap_pct;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    access_t e;
    if (rst_n && out_valid) begin
      if (access_q.size() == 0) begin
        report_mismatch("unexpected result access", out_access, 0);
      end else begin
        e = access_q.pop_front();
        if (out_access !== e.acc) report_mismatch("access", out_access, e.acc);
        if (out_pixel_offset !== e.off) report_mismatch("offset", out_pixel_offset, e.off);
        if (out_write_pixel !== e.pix) report_mismatch("pixel", out_write_pixel, e.pix);
      end
    end
  end

  function automatic void push_access(logic [1:0] acc, logic [23:0] off, logic [15:0] pix);
    access_t a;
    a.acc = acc; a.off = off; a.pix = pix;
    access_q.push_back(a);
  endfunction

  function automatic logic [23:0] locate();
    longint o;
    o = longint'(box_origin) + longint'(row) * stride + col;
    cur_off = o[23:0];
    return cur_off;
  endfunction

  function automatic bit step_box();
    col++;
    if (col > box_w1) begin
      col = 0;
      row++;
      if (row > box_h1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void begin_draw(int px, int py);
    int x, y, w, h, xs, ys;
    longint org;
    x = px - hot_x; y = py - hot_y;
    w = CURSOR_SIZE; h = CURSOR_SIZE; xs = 0; ys = 0;
    if (y < win_y0) begin
      ys = win_y0 - y; h -= ys; y = win_y0;
    end
    if (y + h - 1 > win_y1) h = win_y1 - y + 1;
    if (x < win_x0) begin
      xs = win_x0 - x; w -= xs; x = win_x0;
    end
    if (x + w - 1 > win_x1) w = win_x1 - x + 1;
    draw_after = 1'b0;
    if (w <= 0 || h <= 0) begin
      saved_ok = 1'b0;
      seq_phase = PH_IDLE;
      push_access(ACC_DONE, '0, '0);
      return;
    end
    org = longint'(y) * stride + x;
    box_origin = org[23:0];
    box_w1 = w - 1; box_h1 = h - 1;
    lshift = xs; row0 = ys;
    saved_ok = 1'b1;
    col = 0; row = 0;
    seq_phase = PH_READ;
    push_access(ACC_READ, locate(), '0);
  endfunction

  function automatic void next_pixel();
    if (step_box()) begin
      seq_phase = PH_READ;
      push_access(ACC_READ, locate(), '0);
    end else begin
      seq_phase = PH_IDLE;
      push_access(ACC_DONE, '0, '0);
    end
  endfunction

  function automatic void predict_access(item_t it);
    bit wants_restore, wants_draw, mbit, dbit;
    int sr, pos;
    case (it.kind)
      KIND_SHAPE: begin
        shape_mask[it.row_idx] = it.mask;
        shape_data[it.row_idx] = it.data;
      end
      KIND_COLOUR: begin
        fore_px = it.fg;
        back_px = it.bg;
      end
      KIND_CMD: begin
        wants_restore = (it.op == OP_MOVE || it.op == OP_HIDE_A || it.op == OP_HIDE_B);
        wants_draw = (it.op == OP_MOVE || it.op == OP_SHOW);
        if (seq_phase != PH_IDLE) return;
        if (saved_ok && restore_on && wants_restore) begin
          draw_after = (it.op == OP_MOVE);
          col = 0; row = 0;
          seq_phase = PH_RESTORE;
          push_access(ACC_WRITE, locate(), saved_px[row*CURSOR_SIZE+col]);
        end else if (wants_draw) begin
          begin_draw(int'(it.x), int'(it.y));
        end else begin
          push_access(ACC_DONE, '0, '0);
        end
      end
      default: begin
        case (seq_phase)
          PH_RESTORE: begin
            if (step_box()) begin
              push_access(ACC_WRITE, locate(), saved_px[row*CURSOR_SIZE+col]);
            end else begin
              saved_ok = 1'b0;
              if (draw_after) begin
                begin_draw(int'(it.x), int'(it.y));
              end else begin
                seq_phase = PH_IDLE;
                push_access(ACC_DONE, '0, '0);
              end
            end
          end
          PH_READ: begin
            sr = (row0 + row) % CURSOR_SIZE;
            pos = lshift + col;
            mbit = 1'b0; dbit = 1'b0;
            saved_px[row*CURSOR_SIZE+col] = it.rd;
            if (pos < CURSOR_SIZE) begin
              mbit = shape_mask[sr][CURSOR_SIZE-1-pos];
              dbit = shape_data[sr][CURSOR_SIZE-1-pos];
            end
            if (dbit || mbit) begin
              seq_phase = PH_WRITE;
              push_access(ACC_WRITE, cur_off, dbit ? fore_px : back_px);
            end else begin
              next_pixel();
            end
          end
          PH_WRITE: next_pixel();
          default: ;
        endcase
      end
    endcase
  endfunction

  task automatic send_item(item_t it);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start         <= 1'b1;
    in_kind       <= it.kind;
    in_op         <= it.op;
    in_pos_x      <= it.x;
    in_pos_y      <= it.y;
    in_row_index  <= it.row_idx;
    in_mask_row   <= it.mask;
    in_data_row   <= it.data;
    in_fg_colour  <= it.fg;
    in_bg_colour  <= it.bg;
    in_read_pixel <= it.rd;
    do @(posedge clk); while (busy);
    predict_access(it);
    n_items++;
  endtask

  function automatic item_t rand_item(kind_t k);
    item_t it;
    it.kind = k;
    it.op = 3'($urandom_range(7));
    it.x = 16'($urandom); it.y = 16'($urandom);
    it.row_idx = 4'($urandom_range(15));
    it.mask = 16'($urandom); it.data = 16'($urandom);
    it.fg = 16'($urandom); it.bg = 16'($urandom); it.rd = 16'($urandom);
    return it;
  endfunction

  task automatic settle();
    start <= 1'b0;
    while (access_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_X:  win_x0 = val & 'hfff;
      CFG_MAX_X:  win_x1 = val & 'hfff;
      CFG_MIN_Y:  win_y0 = val & 'hfff;
      CFG_MAX_Y:  win_y1 = val & 'hfff;
      CFG_STRIDE: stride = val & 'h3fff;
      CFG_HOT_X:  hot_x = val & 'hf;
      CFG_HOT_Y:  hot_y = val & 'hf;
      default:    restore_on = val[0];
    endcase
  endtask

  task automatic load_regs(int x0, int x1, int y0, int y1, int str, int hx, int hy, int ren);
    settle();
    write_reg(CFG_MIN_X, x0);
    write_reg(CFG_MAX_X, x1);
    write_reg(CFG_MIN_Y, y0);
    write_reg(CFG_MAX_Y, y1);
    write_reg(CFG_STRIDE, str);
    write_reg(CFG_HOT_X, hx);
    write_reg(CFG_HOT_Y, hy);
    write_reg(CFG_RESTORE, ren);
    cfg_valid <= 1'b0;
  endtask

  // one command and the response traffic it needs, with loads and stray commands mixed in
  task automatic run_cmd(logic [2:0] op, logic [15:0] x, logic signed [15:0] y, int noise);
    item_t it;
    int r;
    it = rand_item(KIND_CMD);
    it.op = op; it.x = x; it.y = y;
    send_item(it);
    while (seq_phase != PH_IDLE) begin
      r = $urandom_range(99);
      if (r < noise) it = rand_item(KIND_SHAPE);
      else if (r < 2 * noise) it = rand_item(KIND_COLOUR);
      else if (r < 3 * noise) it = rand_item(KIND_CMD);
      else begin
        it = rand_item(KIND_RESP);
        if ($urandom_range(9) != 0) begin
          it.x = x; it.y = y;
        end
      end
      send_item(it);
    end
  endtask

  function automatic logic [15:0] near(int lo, int hot);
    return 16'(lo + hot + $urandom_range(0, 24) - 16);
  endfunction

  task automatic test_idle_items();
    item_t it;
    int k;
    it = rand_item(KIND_RESP);
    send_item(it);
    it = rand_item(KIND_CMD); it.op = OP_HIDE_A; send_item(it);
    it.op = OP_HIDE_B; send_item(it);
    for (k = 0; k < 8; k++) begin
      if (k != OP_MOVE && k != OP_HIDE_A && k != OP_SHOW && k != OP_HIDE_B) begin
        it = rand_item(KIND_CMD); it.op = 3'(k); send_item(it);
      end
    end
    it = rand_item(KIND_COLOUR); it.fg = 16'hffff; it.bg = 16'h0000; send_item(it);
    it = rand_item(KIND_SHAPE); it.row_idx = 4'd15; it.mask = '0; it.data = 16'hffff;
    send_item(it);
    it.row_idx = 4'd0; it.mask = 16'hffff; it.data = 16'h8001; send_item(it);
    it.row_idx = 4'd1; it.mask = 16'h0000; it.data = 16'h0000; send_item(it);
  endtask

  task automatic test_draw_small_box();
    item_t it;
    load_regs(100, 101, 50, 51, 640, 3, 2, 1);
    run_cmd(OP_SHOW, 16'd103, 16'sd52, 0);
    run_cmd(OP_MOVE, 16'd102, 16'sd51, 10);
    run_cmd(OP_HIDE_B, 16'd0, 16'sd0, 0);
    run_cmd(OP_SHOW, 16'd88, 16'sd39, 0);
    load_regs(100, 101, 50, 51, 640, 3, 2, 0);
    run_cmd(OP_HIDE_A, 16'd0, 16'sd0, 0);
    run_cmd(OP_MOVE, 16'hffff, -16'sd32768, 0);
    load_regs(200, 100, 60, 40, 0, 15, 15, 1);
    run_cmd(OP_SHOW, 16'd200, 16'sd60, 0);
    it = rand_item(KIND_RESP); send_item(it);
  endtask

  task automatic test_window_extremes();
    load_regs(4094, 4095, 4095, 4095, 8192, 0, 0, 1);
    run_cmd(OP_SHOW, 16'd4094, 16'sd4095, 5);
    run_cmd(OP_MOVE, 16'd4095, 16'sd4094, 5);
    load_regs(0, 2, 0, 1, 16383, 15, 0, 1);
    run_cmd(OP_SHOW, 16'd7, -16'sd1, 5);
    run_cmd(OP_HIDE_A, 16'd0, 16'sd0, 0);
    load_regs(0, 7, 0, 5, 1, 0, 0, 1);
    run_cmd(OP_SHOW, 16'd0, 16'sd0, 3);
    run_cmd(OP_HIDE_A, 16'd0, 16'sd0, 0);
  endtask

  task automatic test_random_traffic();
    int p, x0, x1, y0, y1, str, hx, hy;
    logic [2:0] op;
    item_t it;
    p = 0;
    while (n_items < 550) begin
      x0 = $urandom_range(0, 4095);
      y0 = $urandom_range(0, 4095);
      x1 = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : x0 + $urandom_range(0, 7);
      y1 = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : y0 + $urandom_range(0, 5);
      if (x1 > 4095) x1 = 4095;
      if (y1 > 4095) y1 = 4095;
      str = ($urandom_range(3) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 8192);
      hx = $urandom_range(15);
      hy = $urandom_range(15);
      load_regs(x0, x1, y0, y1, str, hx, hy, ($urandom_range(4) != 0));
      gap_pct = (p == 0) ? 0 : 34;
      for (int c = 0; c < 6 && n_items < 550; c++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: op = OP_MOVE;
          4, 5:       op = OP_SHOW;
          6:          op = OP_HIDE_A;
          7:          op = OP_HIDE_B;
          default:    op = 3'($urandom_range(7));
        endcase
        if ($urandom_range(7) == 0) begin
          it = rand_item(kind_t'($urandom_range(3)));
          send_item(it);
        end
        if ($urandom_range(9) == 0)
          run_cmd(op, 16'($urandom), 16'($urandom), 4);
        else
          run_cmd(op, near(x0, hx), near(y0, hy), 4);
      end
      p++;
    end
    gap_pct = 34;
  endtask

  initial begin
    int i;
    errors = 0; n_items = 0; gap_pct = 34;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_SHAPE; in_op <= '0; in_pos_x <= '0; in_pos_y <= '0;
    in_row_index <= '0; in_mask_row <= '0; in_data_row <= '0;
    in_fg_colour <= '0; in_bg_colour <= '0; in_read_pixel <= '0;
    cfg_valid <= 1'b0; cfg_index <= CFG_MIN_X; cfg_data <= '0;
    win_x0 = 0; win_x1 = 639; win_y0 = 0; win_y1 = 479;
    stride = 640; hot_x = 0; hot_y = 0; restore_on = 1'b1;
    for (i = 0; i < CURSOR_SIZE; i++) begin
      shape_mask[i] = ARROW_MASK[i];
      shape_data[i] = ARROW_DATA[i];
    end
    for (i = 0; i < CURSOR_SIZE*CURSOR_SIZE; i++) saved_px[i] = '0;
    saved_ok = 1'b0; box_origin = '0; box_w1 = 0; box_h1 = 0;
    fore_px = 16'hffff; back_px = '0; seq_phase = PH_IDLE;
    col = 0; row = 0; lshift = 0; row0 = 0; cur_off = '0; draw_after = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_items();
    test_draw_small_box();
    test_window_extremes();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/csb_pkg.sv
sv/csb_datapath.sv
sv/csb_ctrl.sv
sv/cursor_sprite_save_under_blitter.sv
dv/tb_cursor_sprite_save_under_blitter.sv
